FILE: sv/intel_hex_image_loader_unit_defines.svh
// Assertion macros shared by the loader's modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef INTEL_HEX_IMAGE_LOADER_UNIT_DEFINES_SVH
`define INTEL_HEX_IMAGE_LOADER_UNIT_DEFINES_SVH

// Condition c must hold in the same cycle as a.
`define IHEX_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ihex check failed");

// Condition c must hold in the cycle after a.
`define IHEX_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ihex check failed");

`endif

FILE: sv/ihex_pkg.sv
// Package of the hex image loader: sizes, codes and the command passed from
// the parser front end to the commit back end. Depends on nothing.
package ihex_pkg;

  localparam int IMAGE_DEPTH    = 8192;
  localparam int IDENTITY_DEPTH = 512;
  localparam int RECORD_BYTES   = 256;
  localparam int IMG_AW         = $clog2(IMAGE_DEPTH);
  localparam int ID_AW          = $clog2(IDENTITY_DEPTH);
  localparam int REC_AW         = $clog2(RECORD_BYTES);
  localparam int CMD_DEPTH      = 2;
  localparam int CMD_AW         = $clog2(CMD_DEPTH);

  localparam logic [13:0] APP_END_RST    = 14'd6656;
  localparam logic [13:0] EEPROM_END_RST = 14'd7168;

  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_EOI  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_SEG  = 8'h02;
  localparam logic [7:0] REC_ELA  = 8'h04;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic CFG_APP_END    = 1'b0;
  localparam logic CFG_EEPROM_END = 1'b1;

  typedef enum logic [3:0] {
    ST_PARSING    = 4'd0,
    ST_VALID      = 4'd1,
    ST_BAD_HEAD   = 4'd2,
    ST_BAD_DATA   = 4'd3,
    ST_BAD_CSUM   = 4'd4,
    ST_SUM_MISS   = 4'd5,
    ST_BAD_ELA    = 4'd6,
    ST_ABOVE_64K  = 4'd7,
    ST_SEG_REC    = 4'd8,
    ST_TRUNC_HEAD = 4'd9,
    ST_TRUNC_BODY = 4'd10,
    ST_NO_EOF     = 4'd11,
    ST_NO_DATA    = 4'd12
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEAD, PH_DATA, PH_CSUM, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_RBYTE, CMD_COMMIT, CMD_READ, CMD_EOIF
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_CMT_RD, BK_CMT_WR, BK_RESP
  } back_state_t;

  typedef enum logic [1:0] {
    RK_NONE, RK_IMG, RK_ID
  } read_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    status_t     set_status;
    logic [15:0] addr;
    logic [7:0]  len;
    logic [7:0]  data;
  } cmd_t;

endpackage

FILE: sv/ihex_fifo.sv
// Short command queue between the parser front end and the back end.
// Depends on ihex_pkg for the command type and depth.
module ihex_fifo import ihex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CMD_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == (CMD_AW)'(CMD_DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == (CMD_AW)'(CMD_DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/ihex_front.sv
// Parser front end: classifies each accepted item and emits one command.
// Depends on ihex_pkg.
module ihex_front import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  req_type,
  input  logic [7:0]  in_char,
  input  logic [15:0] read_addr,
  output cmd_t        cmd
);

  phase_t      phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic [7:0]  len_r, len_nxt, kind_r, kind_nxt, sum_r, sum_nxt;
  logic [7:0]  b0_r, b0_nxt, b1_r, b1_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        stop_r, stop_nxt;

  logic       nib_ok;
  logic [3:0] nib;
  logic [7:0] byte_val, idx, sum_add;

  always_comb begin
    nib_ok = 1'b1;
    nib    = '0;
    if (in_char inside {[8'h30:8'h39]}) begin
      nib = in_char[3:0];
    end else if (in_char inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      nib = in_char[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign byte_val = {hn_r, nib};
  assign idx      = pos_r[8:1];
  assign sum_add  = sum_r + byte_val;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hn_nxt    = hn_r;
    len_nxt   = len_r;
    kind_nxt  = kind_r;
    sum_nxt   = sum_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    addr_nxt  = addr_r;
    stop_nxt  = stop_r;
    cmd       = '{kind: CMD_NOP, set_status: ST_PARSING, addr: '0, len: '0, data: '0};
    if (accept) begin
      case (req_type)
        REQ_CHAR: begin
          if (!stop_r && phase_r != PH_DONE) begin
            if (phase_r == PH_HUNT) begin
              if (in_char == CHAR_COLON) begin
                phase_nxt = PH_HEAD;
                pos_nxt   = '0;
                sum_nxt   = '0;
              end
            end else if (!nib_ok) begin
              stop_nxt = 1'b1;
              cmd.set_status = (phase_r == PH_HEAD) ? ST_BAD_HEAD :
                               (phase_r == PH_DATA) ? ST_BAD_DATA : ST_BAD_CSUM;
            end else if (!pos_r[0]) begin
              hn_nxt  = nib;
              pos_nxt = pos_r + 1'b1;
            end else begin
              pos_nxt = pos_r + 1'b1;
              sum_nxt = sum_add;
              case (phase_r)
                PH_HEAD: begin
                  case (idx[1:0])
                    2'd0:    len_nxt = byte_val;
                    2'd1:    addr_nxt = {byte_val, 8'h00};
                    2'd2:    addr_nxt = {addr_r[15:8], byte_val};
                    default: begin
                      kind_nxt  = byte_val;
                      pos_nxt   = '0;
                      phase_nxt = (len_r != 8'd0) ? PH_DATA : PH_CSUM;
                    end
                  endcase
                end
                PH_DATA: begin
                  cmd.kind = CMD_RBYTE;
                  cmd.len  = idx;
                  cmd.data = byte_val;
                  if (idx == 8'd0) b0_nxt = byte_val;
                  if (idx == 8'd1) b1_nxt = byte_val;
                  if ({1'b0, idx} + 9'd1 >= {1'b0, len_r}) begin
                    pos_nxt   = '0;
                    phase_nxt = PH_CSUM;
                  end
                end
                default: begin
                  if (sum_add != 8'd0) begin
                    stop_nxt = 1'b1;
                    cmd.set_status = ST_SUM_MISS;
                  end else begin
                    phase_nxt = PH_HUNT;
                    case (kind_r)
                      REC_DATA: begin
                        cmd.kind = CMD_COMMIT;
                        cmd.addr = addr_r;
                        cmd.len  = len_r;
                      end
                      REC_EOF: phase_nxt = PH_DONE;
                      REC_ELA: begin
                        if (len_r != 8'd2) begin
                          stop_nxt = 1'b1;
                          cmd.set_status = ST_BAD_ELA;
                        end else if (b0_r != 8'd0 || b1_r != 8'd0) begin
                          stop_nxt = 1'b1;
                          cmd.set_status = ST_ABOVE_64K;
                        end
                      end
                      REC_SEG: begin
                        stop_nxt = 1'b1;
                        cmd.set_status = ST_SEG_REC;
                      end
                      default: ;
                    endcase
                  end
                end
              endcase
            end
          end
        end
        REQ_EOI: begin
          if (!stop_r) begin
            stop_nxt = 1'b1;
            case (phase_r)
              PH_HEAD: cmd.set_status = ST_TRUNC_HEAD;
              PH_DATA, PH_CSUM: cmd.set_status = ST_TRUNC_BODY;
              PH_DONE: cmd.kind = CMD_EOIF;
              default: cmd.set_status = ST_NO_EOF;
            endcase
          end
        end
        REQ_READ: begin
          cmd.kind = CMD_READ;
          cmd.addr = read_addr;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      hn_r    <= '0;
      len_r   <= '0;
      kind_r  <= '0;
      sum_r   <= '0;
      addr_r  <= '0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hn_r    <= hn_nxt;
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
      sum_r   <= sum_nxt;
      addr_r  <= addr_nxt;
      stop_r  <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
  end

endmodule

FILE: sv/ihex_back.sv
// Back end: executes commands, owns the record buffer, image, marks and
// identity memories, and forms the result. Depends on ihex_pkg and the defines header.
`include "intel_hex_image_loader_unit_defines.svh"
module ihex_back import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [13:0] app_end,
  input  logic [13:0] eeprom_end,
  input  cmd_t        head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_status,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic [15:0] out_min_addr,
  output logic [13:0] out_max_addr,
  output logic [15:0] out_boot_skipped,
  output logic        out_has_identity
);

  logic [7:0] rbuf [RECORD_BYTES];
  logic [7:0] img  [IMAGE_DEPTH];
  logic       mark [IMAGE_DEPTH];
  logic [7:0] idm  [IDENTITY_DEPTH];

  back_state_t state_r, state_nxt;
  logic [IMG_AW-1:0] clr_r, clr_nxt;
  logic [7:0]  k_r, k_nxt, clen_r, clen_nxt;
  logic [15:0] base_r, base_nxt;
  read_kind_t  rk_r, rk_nxt;
  status_t     status_r, status_nxt;
  logic [15:0] min_r, min_nxt, skip_r, skip_nxt;
  logic [13:0] max_r, max_nxt;
  logic        seen_r, seen_nxt, ov_r, ov_nxt;
  logic [7:0]  rb_q, img_q, id_q;
  logic        mark_q;

  logic [16:0] wa, wix;
  logic [15:0] rix;
  logic        img_we, id_we, mark_we, mark_wd, rb_we;
  logic [IMG_AW-1:0] mark_wa;

  assign clearing  = (state_r == BK_CLEAR);
  assign out_empty = !ov_r;
  assign wa  = {1'b0, base_r} + {9'd0, k_r};
  assign wix = wa - {3'd0, app_end};
  assign rix = head.addr - {2'd0, app_end};

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    k_nxt      = k_r;
    clen_nxt   = clen_r;
    base_nxt   = base_r;
    rk_nxt     = rk_r;
    status_nxt = status_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    skip_nxt   = skip_r;
    seen_nxt   = seen_r;
    ov_nxt     = ov_r && !out_pop;
    q_pop      = 1'b0;
    img_we     = 1'b0;
    id_we      = 1'b0;
    rb_we      = 1'b0;
    mark_we    = 1'b0;
    mark_wd    = 1'b0;
    mark_wa    = wa[IMG_AW-1:0];
    case (state_r)
      BK_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IMG_AW)'(IMAGE_DEPTH-1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty && !ov_r) begin
          q_pop     = 1'b1;
          rk_nxt    = RK_NONE;
          state_nxt = BK_RESP;
          if (head.set_status != ST_PARSING) status_nxt = head.set_status;
          case (head.kind)
            CMD_RBYTE: rb_we = 1'b1;
            CMD_EOIF:  status_nxt = (max_r == '0) ? ST_NO_DATA : ST_VALID;
            CMD_READ: begin
              if (head.addr < {2'd0, app_end}) begin
                if ({1'b0, head.addr} < 17'(IMAGE_DEPTH)) rk_nxt = RK_IMG;
              end else if (head.addr < {2'd0, eeprom_end} &&
                           {1'b0, rix} < 17'(IDENTITY_DEPTH)) begin
                rk_nxt = RK_ID;
              end
            end
            CMD_COMMIT: begin
              base_nxt = head.addr;
              clen_nxt = head.len;
              k_nxt    = '0;
              if (head.len != 8'd0) state_nxt = BK_CMT_RD;
            end
            default: ;
          endcase
        end
      end
      BK_CMT_RD: state_nxt = BK_CMT_WR;
      BK_CMT_WR: begin
        if (wa < {3'd0, app_end}) begin
          if (wa < 17'(IMAGE_DEPTH)) begin
            img_we  = 1'b1;
            mark_we = 1'b1;
            mark_wd = 1'b1;
            if (wa[15:0] < min_r) min_nxt = wa[15:0];
            if (wa + 17'd1 > {3'd0, max_r}) max_nxt = 14'(wa + 17'd1);
          end
        end else if (wa < {3'd0, eeprom_end}) begin
          if (wix < 17'(IDENTITY_DEPTH)) begin
            id_we    = 1'b1;
            seen_nxt = 1'b1;
          end
        end else if (skip_r != 16'hFFFF) begin
          skip_nxt = skip_r + 1'b1;
        end
        if (k_r == clen_r - 8'd1) begin
          state_nxt = BK_RESP;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = BK_CMT_RD;
        end
      end
      BK_RESP: begin
        ov_nxt    = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_CLEAR;
      clr_r    <= '0;
      status_r <= ST_PARSING;
      min_r    <= 16'hFFFF;
      max_r    <= '0;
      skip_r   <= '0;
      seen_r   <= 1'b0;
      ov_r     <= 1'b0;
      rk_r     <= RK_NONE;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      status_r <= status_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      skip_r   <= skip_nxt;
      seen_r   <= seen_nxt;
      ov_r     <= ov_nxt;
      rk_r     <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    clen_r <= clen_nxt;
    base_r <= base_nxt;
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (rb_we) rbuf[head.len[REC_AW-1:0]] <= head.data;
    rb_q <= rbuf[k_r[REC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (img_we) img[wa[IMG_AW-1:0]] <= rb_q;
    img_q <= img[head.addr[IMG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark[mark_wa] <= mark_wd;
    mark_q <= mark[head.addr[IMG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (id_we) idm[wix[ID_AW-1:0]] <= rb_q;
    id_q <= idm[rix[ID_AW-1:0]];
  end

  // Result register, loaded in the response state.
  always_ff @(posedge clk) begin
    if (state_r == BK_RESP) begin
      out_status       <= status_r;
      out_min_addr     <= min_r;
      out_max_addr     <= max_r;
      out_boot_skipped <= skip_r;
      out_has_identity <= seen_r;
      case (rk_r)
        RK_IMG: begin
          out_read_data  <= mark_q ? img_q : 8'd0;
          out_read_valid <= mark_q;
        end
        RK_ID: begin
          out_read_data  <= id_q;
          out_read_valid <= seen_r;
        end
        default: begin
          out_read_data  <= 8'd0;
          out_read_valid <= 1'b0;
        end
      endcase
    end
  end

  `IHEX_ASSERT_NEXT(a_rd_then_wr, state_r == BK_CMT_RD, state_r == BK_CMT_WR)
  `IHEX_ASSERT_SAME(a_pop_slot_free, q_pop, !ov_r && !q_empty && state_r == BK_IDLE)
  `IHEX_ASSERT_SAME(a_max_bound, 1'b1, max_r <= 14'(IMAGE_DEPTH))
  `IHEX_ASSERT_SAME(a_no_pop_clear, clearing, !q_pop && !ov_r)

endmodule

FILE: sv/intel_hex_image_loader_unit.sv
// Top level of the hex image loader: configuration registers, the parser
// front end, the command queue and the back end. Depends on ihex_pkg and its modules.
//
// Usage. The input channel is a queue: drive req_type, in_char and read_addr
// with in_push; a transaction completes when in_push is high and in_full low.
// Each input transaction yields exactly one result on the out_ channel, in
// order, presented while out_empty is low and taken when out_pop is high.
// The front end classifies a character, end of input or read in the cycle it
// is accepted and queues one command; the back end takes a command only when
// its result register is free: a popped command passes through the response
// state into that register, and no new command is taken until it is popped.
// A checksum character that completes a data record makes the back end walk
// the buffered bytes, each with a record buffer read and then an image,
// identity or skip update, before the response state loads its result.
// When the receiver stalls, the result register holds, the back end stops,
// and the two-entry queue fills until in_full rises.
// After reset the written marks of the image are cleared, one entry a cycle,
// with in_full high until all 8192 are clear. Configuration writes (app_end,
// then eeprom_end) are always taken, cfg_ready is tied high; write only when idle.
module intel_hex_image_loader_unit import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_in_char,
  input  logic [15:0] in_read_addr,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_status,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic [15:0] out_min_addr,
  output logic [13:0] out_max_addr,
  output logic [15:0] out_boot_skipped,
  output logic        out_has_identity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  logic [13:0] app_end_r, eeprom_end_r;
  logic        accept, q_full, q_empty, q_pop, clearing;
  cmd_t        cmd, head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full || clearing;
  assign accept    = in_push && !in_full;

  // Indexes past the register list are accepted and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_end_r    <= APP_END_RST;
      eeprom_end_r <= EEPROM_END_RST;
    end else if (cfg_valid && cfg_index[1] == 1'b0) begin
      if (cfg_index[0] == CFG_APP_END) app_end_r <= cfg_data;
      else eeprom_end_r <= cfg_data;
    end
  end

  ihex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .in_char   (in_in_char),
    .read_addr (in_read_addr),
    .cmd       (cmd)
  );

  ihex_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  ihex_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .app_end          (app_end_r),
    .eeprom_end       (eeprom_end_r),
    .head             (head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_read_data    (out_read_data),
    .out_read_valid   (out_read_valid),
    .out_min_addr     (out_min_addr),
    .out_max_addr     (out_max_addr),
    .out_boot_skipped (out_boot_skipped),
    .out_has_identity (out_has_identity)
  );

endmodule
